// ----- rtl/cvos_pkg.sv -----
// Shared types, widths and codes for the closest view observation select block.
// Used by cvos_ctrl, cvos_dp and closest_view_observation_select_top.
package cvos_pkg;

   // table geometry
   localparam int MAX_OBSERVATIONS = 16;
   localparam int IDX_W = (MAX_OBSERVATIONS > 1) ? $clog2(MAX_OBSERVATIONS) : 1;
   localparam int CNT_W = $clog2(MAX_OBSERVATIONS + 1);

   // field widths
   localparam int KIND_W    = 2;
   localparam int KEY_W     = 16;
   localparam int COORD_W   = 32;
   localparam int STATUS_W  = 3;
   localparam int COS_W     = 16;
   localparam int CSR_IDX_W = 2;

   // arithmetic widths
   localparam int VEC_DIM = 3;
   localparam int DIFF_W  = COORD_W + 1;   // exact camera minus point
   localparam int RED_W   = 16;            // reduced component, magnitude below 2^15
   localparam int NORM_W  = 32;            // sum of three squares
   localparam int DOT_W   = 34;
   localparam int PROD_W  = 64;
   localparam int FRAC_W  = 14;            // Q1.14 cosine scale
   localparam int NUM_W   = NORM_W + FRAC_W;
   localparam int QUO_W   = 15;
   localparam int STEP_W  = 5;

   localparam int SQRT_STEPS = PROD_W / 2;
   localparam int DIV_STEPS  = QUO_W;

   localparam logic signed [COS_W-1:0] COS_ONE  = 16'sd16384;
   localparam logic signed [COS_W-1:0] COS_HALF = 16'sd8192;

   // item kinds
   localparam logic [KIND_W-1:0] KIND_ADD   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FIND  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DEL   = 2'd2;
   localparam logic [KIND_W-1:0] KIND_QUERY = 2'd3;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_ANGLE    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_POINT_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POINT_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_POINT_Z = 2'd2;

   // memory read address select
   localparam logic [1:0] RD_IDX = 2'd0;
   localparam logic [1:0] RD_DEC = 2'd1;
   localparam logic [1:0] RD_INC = 2'd2;

   // index register operations
   localparam logic [2:0] IDX_HOLD  = 3'd0;
   localparam logic [2:0] IDX_ZERO  = 3'd1;
   localparam logic [2:0] IDX_COUNT = 3'd2;
   localparam logic [2:0] IDX_INC   = 3'd3;
   localparam logic [2:0] IDX_DEC   = 3'd4;

   // result register operations
   localparam logic [2:0] RES_HOLD     = 3'd0;
   localparam logic [2:0] RES_FULL     = 3'd1;
   localparam logic [2:0] RES_NOTFOUND = 3'd2;
   localparam logic [2:0] RES_EMPTY    = 3'd3;
   localparam logic [2:0] RES_ADDED    = 3'd4;
   localparam logic [2:0] RES_MATCH    = 3'd5;
   localparam logic [2:0] RES_BEST     = 3'd6;

   typedef struct packed {
      logic [KEY_W-1:0]          frame;
      logic [KEY_W-1:0]          feature;
      logic signed [COORD_W-1:0] cam_x;
      logic signed [COORD_W-1:0] cam_y;
      logic signed [COORD_W-1:0] cam_z;
   } entry_type;

   // controller to datapath
   typedef struct packed {
      logic       load_req;
      logic       mem_rd;
      logic [1:0] rd_sel;
      logic       mem_wr;
      logic       wr_new;
      logic [2:0] idx_op;
      logic       cnt_inc;
      logic       cnt_dec;
      logic [2:0] res_op;
      logic       red_load_q;
      logic       red_load_e;
      logic       red_shift;
      logic       red_save_q;
      logic       mac_clr;
      logic       mac_step;
      logic [1:0] comp;
      logic       mul_go;
      logic       sqrt_init;
      logic       sqrt_step;
      logic       div_init;
      logic       div_step;
      logic       div_fin;
      logic       cos_zero;
      logic       best_clr;
      logic       cmp_go;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              full;
      logic              empty;
      logic              last;
      logic              idx_zero;
      logic              match;
      logic              red_big;
      logic              red_zero;
      logic              qzero;
   } sts_type;

endpackage

// ----- rtl/cvos_ctrl.sv -----
// Sequencer for the observation table: add/find/delete sweeps and the per-entry
// cosine steps. Depends on cvos_pkg; drives cvos_dp through cmd_type/sts_type.
module cvos_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   output logic              rsp_valid,
   output cvos_pkg::cmd_type cmd,
   input  cvos_pkg::sts_type sts
);
   import cvos_pkg::*;

   localparam logic [4:0] S_IDLE     = 5'd0;
   localparam logic [4:0] S_DECODE   = 5'd1;
   localparam logic [4:0] S_ADD_CHK  = 5'd2;
   localparam logic [4:0] S_ADD_WR   = 5'd3;
   localparam logic [4:0] S_SCAN_RD  = 5'd4;
   localparam logic [4:0] S_SCAN_CMP = 5'd5;
   localparam logic [4:0] S_DEL_CHK  = 5'd6;
   localparam logic [4:0] S_DEL_WR   = 5'd7;
   localparam logic [4:0] S_QRED     = 5'd8;
   localparam logic [4:0] S_QE_RD    = 5'd9;
   localparam logic [4:0] S_QE_LOAD  = 5'd10;
   localparam logic [4:0] S_QE_RED   = 5'd11;
   localparam logic [4:0] S_QE_MAC   = 5'd12;
   localparam logic [4:0] S_QE_MUL   = 5'd13;
   localparam logic [4:0] S_QE_SQI   = 5'd14;
   localparam logic [4:0] S_QE_SQ    = 5'd15;
   localparam logic [4:0] S_QE_DVI   = 5'd16;
   localparam logic [4:0] S_QE_DV    = 5'd17;
   localparam logic [4:0] S_QE_FIN   = 5'd18;
   localparam logic [4:0] S_QE_CMP   = 5'd19;
   localparam logic [4:0] S_QDONE    = 5'd20;
   localparam logic [4:0] S_RESP     = 5'd21;

   logic [4:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load_req = 1'b1;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            case (sts.kind)
               KIND_ADD: begin
                  if (sts.full) begin
                     cmd.res_op = RES_FULL;
                     state_in   = S_RESP;
                  end else begin
                     cmd.idx_op = IDX_COUNT;
                     state_in   = S_ADD_CHK;
                  end
               end
               KIND_FIND, KIND_DEL: begin
                  if (sts.empty) begin
                     cmd.res_op = RES_NOTFOUND;
                     state_in   = S_RESP;
                  end else begin
                     cmd.idx_op = IDX_ZERO;
                     state_in   = S_SCAN_RD;
                  end
               end
               default: begin
                  if (sts.empty) begin
                     cmd.res_op = RES_EMPTY;
                     state_in   = S_RESP;
                  end else begin
                     cmd.red_load_q = 1'b1;
                     state_in       = S_QRED;
                  end
               end
            endcase
         end
         // shift entries up one place, newest goes in at index 0
         S_ADD_CHK: begin
            if (sts.idx_zero) begin
               cmd.mem_wr  = 1'b1;
               cmd.wr_new  = 1'b1;
               cmd.cnt_inc = 1'b1;
               cmd.res_op  = RES_ADDED;
               state_in    = S_RESP;
            end else begin
               cmd.mem_rd = 1'b1;
               cmd.rd_sel = RD_DEC;
               state_in   = S_ADD_WR;
            end
         end
         S_ADD_WR: begin
            cmd.mem_wr = 1'b1;
            cmd.idx_op = IDX_DEC;
            state_in   = S_ADD_CHK;
         end
         // search newest first
         S_SCAN_RD: begin
            cmd.mem_rd = 1'b1;
            cmd.rd_sel = RD_IDX;
            state_in   = S_SCAN_CMP;
         end
         S_SCAN_CMP: begin
            if (sts.match) begin
               cmd.res_op = RES_MATCH;
               state_in   = (sts.kind == KIND_DEL) ? S_DEL_CHK : S_RESP;
            end else if (sts.last) begin
               cmd.res_op = RES_NOTFOUND;
               state_in   = S_RESP;
            end else begin
               cmd.idx_op = IDX_INC;
               state_in   = S_SCAN_RD;
            end
         end
         // close the gap left by a deleted entry
         S_DEL_CHK: begin
            if (sts.last) begin
               cmd.cnt_dec = 1'b1;
               state_in    = S_RESP;
            end else begin
               cmd.mem_rd = 1'b1;
               cmd.rd_sel = RD_INC;
               state_in   = S_DEL_WR;
            end
         end
         S_DEL_WR: begin
            cmd.mem_wr = 1'b1;
            cmd.idx_op = IDX_INC;
            state_in   = S_DEL_CHK;
         end
         // reduce the query direction once
         S_QRED: begin
            if (sts.red_big) begin
               cmd.red_shift = 1'b1;
            end else begin
               cmd.red_save_q = 1'b1;
               cmd.idx_op     = IDX_ZERO;
               cmd.best_clr   = 1'b1;
               state_in       = S_QE_RD;
            end
         end
         S_QE_RD: begin
            cmd.mem_rd = 1'b1;
            cmd.rd_sel = RD_IDX;
            state_in   = S_QE_LOAD;
         end
         S_QE_LOAD: begin
            cmd.red_load_e = 1'b1;
            cmd.mac_clr    = 1'b1;
            state_in       = S_QE_RED;
         end
         S_QE_RED: begin
            if (sts.red_big) begin
               cmd.red_shift = 1'b1;
            end else if (sts.red_zero || sts.qzero) begin
               cmd.cos_zero = 1'b1;
               state_in     = S_QE_CMP;
            end else begin
               state_in = S_QE_MAC;
            end
         end
         S_QE_MAC: begin
            cmd.mac_step = 1'b1;
            cmd.comp     = step_ff[1:0];
            if (step_ff == STEP_W'(VEC_DIM - 1)) begin
               step_in  = '0;
               state_in = S_QE_MUL;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_QE_MUL: begin
            cmd.mul_go = 1'b1;
            state_in   = S_QE_SQI;
         end
         S_QE_SQI: begin
            cmd.sqrt_init = 1'b1;
            state_in      = S_QE_SQ;
         end
         S_QE_SQ: begin
            cmd.sqrt_step = 1'b1;
            if (step_ff == STEP_W'(SQRT_STEPS - 1)) begin
               step_in  = '0;
               state_in = S_QE_DVI;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_QE_DVI: begin
            cmd.div_init = 1'b1;
            state_in     = S_QE_DV;
         end
         S_QE_DV: begin
            cmd.div_step = 1'b1;
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               step_in  = '0;
               state_in = S_QE_FIN;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_QE_FIN: begin
            cmd.div_fin = 1'b1;
            state_in    = S_QE_CMP;
         end
         S_QE_CMP: begin
            cmd.cmp_go = 1'b1;
            if (sts.last) begin
               state_in = S_QDONE;
            end else begin
               cmd.idx_op = IDX_INC;
               state_in   = S_QE_RD;
            end
         end
         S_QDONE: begin
            cmd.res_op = RES_BEST;
            state_in   = S_RESP;
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

`ifndef SYNTHESIS
   property p_rsp_one_cycle;
      @(posedge clock) disable iff (reset) rsp_valid |=> !rsp_valid;
   endproperty
   a_rsp_one_cycle: assert property (p_rsp_one_cycle)
      else $error("result strobe longer than one cycle");

   property p_accept_busy;
      @(posedge clock) disable iff (reset) (start && !busy) |=> busy;
   endproperty
   a_accept_busy: assert property (p_accept_busy)
      else $error("accepted word did not raise busy");

   property p_rsp_then_idle;
      @(posedge clock) disable iff (reset) rsp_valid |=> !busy;
   endproperty
   a_rsp_then_idle: assert property (p_rsp_then_idle)
      else $error("not idle after result");

   property p_no_add_when_full;
      @(posedge clock) disable iff (reset) cmd.cnt_inc |-> !sts.full;
   endproperty
   a_no_add_when_full: assert property (p_no_add_when_full)
      else $error("entry added to a full table");
`endif

endmodule

// ----- rtl/cvos_dp.sv -----
// Datapath: point registers, entry memory, direction reducer, multiply-accumulate,
// bit-serial square root and divider, best-view tracking. Depends on cvos_pkg.
module cvos_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [cvos_pkg::KIND_W-1:0]           req_kind,
   input  logic [cvos_pkg::KEY_W-1:0]            req_frame_key,
   input  logic [cvos_pkg::KEY_W-1:0]            req_feature_handle,
   input  logic signed [cvos_pkg::COORD_W-1:0]   req_cam_x,
   input  logic signed [cvos_pkg::COORD_W-1:0]   req_cam_y,
   input  logic signed [cvos_pkg::COORD_W-1:0]   req_cam_z,
   input  logic                                  csr_wr,
   input  logic [cvos_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [cvos_pkg::COORD_W-1:0]          csr_data,
   input  cvos_pkg::cmd_type                     cmd,
   output cvos_pkg::sts_type                     sts,
   output logic [cvos_pkg::STATUS_W-1:0]         rsp_status,
   output logic [cvos_pkg::KEY_W-1:0]            rsp_found_feature,
   output logic signed [cvos_pkg::COS_W-1:0]     rsp_best_cosine
);
   import cvos_pkg::*;

   logic signed [COORD_W-1:0] point_ff [VEC_DIM];
   logic [KIND_W-1:0]         kind_ff;
   logic [KEY_W-1:0]          key_ff;
   logic [KEY_W-1:0]          feat_ff;
   logic signed [COORD_W-1:0] cam_ff [VEC_DIM];

   entry_type                 entry_mem [MAX_OBSERVATIONS];
   entry_type                 rd_data_ff;
   entry_type                 wr_data;
   logic [IDX_W-1:0]          rd_addr;
   logic [IDX_W-1:0]          wr_addr;

   logic [IDX_W-1:0]          idx_ff, idx_in;
   logic [CNT_W-1:0]          count_ff, count_in;

   logic signed [COORD_W-1:0] ent_cam [VEC_DIM];
   logic signed [COORD_W-1:0] src_cam [VEC_DIM];
   logic signed [DIFF_W-1:0]  diff [VEC_DIM];
   logic [DIFF_W-1:0]         red_mag_ff [VEC_DIM];
   logic                      red_neg_ff [VEC_DIM];
   logic signed [RED_W-1:0]   red_val [VEC_DIM];
   logic [VEC_DIM-1:0]        big_vec;
   logic [VEC_DIM-1:0]        nz_vec;
   logic signed [RED_W-1:0]   qa_ff [VEC_DIM];
   logic                      qzero_ff;
   logic [KEY_W-1:0]          ent_feat_ff;

   logic signed [RED_W-1:0]   mac_a;
   logic signed [RED_W-1:0]   mac_b;
   logic signed [2*RED_W-1:0] prod_ab;
   logic signed [2*RED_W-1:0] prod_aa;
   logic signed [2*RED_W-1:0] prod_bb;
   logic signed [DOT_W-1:0]   dot_ff;
   logic [NORM_W-1:0]         na_ff;
   logic [NORM_W-1:0]         nb_ff;
   logic [PROD_W-1:0]         prod_ff;

   logic [PROD_W-1:0]         sq_x_ff;
   logic [PROD_W-1:0]         sq_r_ff;
   logic [PROD_W-1:0]         sq_bit_ff;
   logic [PROD_W-1:0]         sq_try;

   logic [DOT_W-1:0]          dot_mag;
   logic [NORM_W-1:0]         den;
   logic [NUM_W-1:0]          num;
   logic [NUM_W-1:0]          rem_ff;
   logic [NUM_W-1:0]          dsh_ff;
   logic [QUO_W-1:0]          quo_ff;
   logic                      ovf_ff;
   logic                      dneg_ff;
   logic [COS_W-1:0]          cos_mag;
   logic signed [COS_W-1:0]   cos_ff;
   logic signed [COS_W-1:0]   best_ff;
   logic [KEY_W-1:0]          best_feat_ff;

   logic [STATUS_W-1:0]       res_status_ff;
   logic [KEY_W-1:0]          res_feat_ff;
   logic signed [COS_W-1:0]   res_cos_ff;

   // point position registers
   always_ff @(posedge clock) begin
      if (reset) begin
         point_ff[0] <= '0;
         point_ff[1] <= '0;
         point_ff[2] <= '0;
      end else if (csr_wr) begin
         case (csr_index)
            CSR_POINT_X: point_ff[0] <= csr_data;
            CSR_POINT_Y: point_ff[1] <= csr_data;
            CSR_POINT_Z: point_ff[2] <= csr_data;
            default: ;
         endcase
      end
   end

   // request word capture
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         kind_ff   <= req_kind;
         key_ff    <= req_frame_key;
         feat_ff   <= req_feature_handle;
         cam_ff[0] <= req_cam_x;
         cam_ff[1] <= req_cam_y;
         cam_ff[2] <= req_cam_z;
      end
   end

   // entry memory, one read and one write port, registered read
   always_comb begin
      case (cmd.rd_sel)
         RD_DEC:  rd_addr = idx_ff - IDX_W'(1);
         RD_INC:  rd_addr = idx_ff + IDX_W'(1);
         default: rd_addr = idx_ff;
      endcase
      wr_addr = cmd.wr_new ? '0 : idx_ff;
      if (cmd.wr_new) begin
         wr_data.frame   = key_ff;
         wr_data.feature = feat_ff;
         wr_data.cam_x   = cam_ff[0];
         wr_data.cam_y   = cam_ff[1];
         wr_data.cam_z   = cam_ff[2];
      end else begin
         wr_data = rd_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_wr) begin
         entry_mem[wr_addr] <= wr_data;
      end
      if (cmd.mem_rd) begin
         rd_data_ff <= entry_mem[rd_addr];
      end
   end

   // scan index and fill count
   always_comb begin
      case (cmd.idx_op)
         IDX_ZERO:  idx_in = '0;
         IDX_COUNT: idx_in = count_ff[IDX_W-1:0];
         IDX_INC:   idx_in = idx_ff + IDX_W'(1);
         IDX_DEC:   idx_in = idx_ff - IDX_W'(1);
         default:   idx_in = idx_ff;
      endcase
      count_in = count_ff;
      if (cmd.cnt_inc) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      idx_ff <= idx_in;
   end

   // direction reducer: load sign and magnitude, shift right until below 2^15
   assign ent_cam[0] = rd_data_ff.cam_x;
   assign ent_cam[1] = rd_data_ff.cam_y;
   assign ent_cam[2] = rd_data_ff.cam_z;

   always_comb begin
      for (int j = 0; j < VEC_DIM; j++) begin
         src_cam[j] = cmd.red_load_q ? cam_ff[j] : ent_cam[j];
         diff[j]    = {src_cam[j][COORD_W-1], src_cam[j]} -
                      {point_ff[j][COORD_W-1], point_ff[j]};
         big_vec[j] = |red_mag_ff[j][DIFF_W-1:RED_W-1];
         nz_vec[j]  = |red_mag_ff[j];
         red_val[j] = red_neg_ff[j] ? -$signed(red_mag_ff[j][RED_W-1:0])
                                    : $signed(red_mag_ff[j][RED_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < VEC_DIM; j++) begin
         if (cmd.red_load_q || cmd.red_load_e) begin
            red_neg_ff[j] <= diff[j][DIFF_W-1];
            red_mag_ff[j] <= diff[j][DIFF_W-1] ? DIFF_W'(-diff[j]) : DIFF_W'(diff[j]);
         end else if (cmd.red_shift) begin
            red_mag_ff[j] <= red_mag_ff[j] >> 1;
         end
         if (cmd.red_save_q) begin
            qa_ff[j] <= red_val[j];
         end
      end
      if (cmd.red_save_q) begin
         qzero_ff <= ~|nz_vec;
      end
      if (cmd.red_load_e) begin
         ent_feat_ff <= rd_data_ff.feature;
      end
   end

   // dot product and squared norms, one component a cycle
   assign mac_a   = qa_ff[cmd.comp];
   assign mac_b   = red_val[cmd.comp];
   assign prod_ab = mac_a * mac_b;
   assign prod_aa = mac_a * mac_a;
   assign prod_bb = mac_b * mac_b;

   always_ff @(posedge clock) begin
      if (cmd.mac_clr) begin
         dot_ff <= '0;
         na_ff  <= '0;
         nb_ff  <= '0;
      end else if (cmd.mac_step) begin
         dot_ff <= dot_ff + DOT_W'(prod_ab);
         na_ff  <= na_ff + NORM_W'($unsigned(prod_aa));
         nb_ff  <= nb_ff + NORM_W'($unsigned(prod_bb));
      end
      if (cmd.mul_go) begin
         prod_ff <= PROD_W'(na_ff) * PROD_W'(nb_ff);
      end
   end

   // floor square root, two bits of radicand a cycle
   assign sq_try = sq_r_ff + sq_bit_ff;

   always_ff @(posedge clock) begin
      if (cmd.sqrt_init) begin
         sq_x_ff   <= prod_ff;
         sq_r_ff   <= '0;
         sq_bit_ff <= PROD_W'(1) << (PROD_W - 2);
      end else if (cmd.sqrt_step) begin
         if (sq_x_ff >= sq_try) begin
            sq_x_ff <= sq_x_ff - sq_try;
            sq_r_ff <= (sq_r_ff >> 1) + sq_bit_ff;
         end else begin
            sq_r_ff <= sq_r_ff >> 1;
         end
         sq_bit_ff <= sq_bit_ff >> 2;
      end
   end

   // restoring divide of |dot| * 2^14 by the root, one quotient bit a cycle
   assign dot_mag = dot_ff[DOT_W-1] ? DOT_W'(-dot_ff) : DOT_W'(dot_ff);
   assign den     = sq_r_ff[NORM_W-1:0];
   assign num     = {dot_mag[NORM_W-1:0], {FRAC_W{1'b0}}};
   assign cos_mag = (ovf_ff || ({1'b0, quo_ff} > COS_ONE)) ? COS_ONE : {1'b0, quo_ff};

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         rem_ff  <= num;
         dsh_ff  <= {den, {FRAC_W{1'b0}}};
         ovf_ff  <= ({1'b0, num} >= {den, {(FRAC_W + 1){1'b0}}});
         quo_ff  <= '0;
         dneg_ff <= dot_ff[DOT_W-1];
      end else if (cmd.div_step) begin
         if (rem_ff >= dsh_ff) begin
            rem_ff <= rem_ff - dsh_ff;
            quo_ff <= {quo_ff[QUO_W-2:0], 1'b1};
         end else begin
            quo_ff <= {quo_ff[QUO_W-2:0], 1'b0};
         end
         dsh_ff <= dsh_ff >> 1;
      end
      if (cmd.cos_zero) begin
         cos_ff <= '0;
      end else if (cmd.div_fin) begin
         cos_ff <= dneg_ff ? -$signed(cos_mag) : $signed(cos_mag);
      end
   end

   // running best: first entry of strictly highest cosine, floor at zero
   always_ff @(posedge clock) begin
      if (cmd.best_clr) begin
         best_ff <= '0;
      end else if (cmd.cmp_go) begin
         if (cos_ff > best_ff) begin
            best_ff <= cos_ff;
         end
      end
      if (cmd.cmp_go && ((idx_ff == '0) || (cos_ff > best_ff))) begin
         best_feat_ff <= ent_feat_ff;
      end
   end

   // result word
   always_ff @(posedge clock) begin
      case (cmd.res_op)
         RES_FULL: begin
            res_status_ff <= ST_FULL;
            res_feat_ff   <= '0;
            res_cos_ff    <= '0;
         end
         RES_NOTFOUND: begin
            res_status_ff <= ST_NOTFOUND;
            res_feat_ff   <= '0;
            res_cos_ff    <= '0;
         end
         RES_EMPTY: begin
            res_status_ff <= ST_EMPTY;
            res_feat_ff   <= '0;
            res_cos_ff    <= '0;
         end
         RES_ADDED: begin
            res_status_ff <= ST_OK;
            res_feat_ff   <= '0;
            res_cos_ff    <= '0;
         end
         RES_MATCH: begin
            res_status_ff <= ST_OK;
            res_feat_ff   <= rd_data_ff.feature;
            res_cos_ff    <= '0;
         end
         RES_BEST: begin
            res_status_ff <= (best_ff < COS_HALF) ? ST_ANGLE : ST_OK;
            res_feat_ff   <= best_feat_ff;
            res_cos_ff    <= best_ff;
         end
         default: ;
      endcase
   end

   assign rsp_status        = res_status_ff;
   assign rsp_found_feature = res_feat_ff;
   assign rsp_best_cosine   = res_cos_ff;

   // status to the controller
   assign sts.kind     = kind_ff;
   assign sts.full     = (count_ff >= CNT_W'(MAX_OBSERVATIONS));
   assign sts.empty    = (count_ff == '0);
   assign sts.last     = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);
   assign sts.idx_zero = (idx_ff == '0);
   assign sts.match    = (rd_data_ff.frame == key_ff);
   assign sts.red_big  = |big_vec;
   assign sts.red_zero = ~|nz_vec;
   assign sts.qzero    = qzero_ff;

endmodule

// ----- rtl/closest_view_observation_select_top.sv -----
// Top level of the closest view observation select block.
// Depends on cvos_pkg; instantiates cvos_ctrl and cvos_dp.
//
// Usage: a word is taken when start is high and busy is low; busy stays high
// until the result has been shown. The result appears on rsp_status,
// rsp_found_feature and rsp_best_cosine for exactly one cycle with rsp_valid
// high; the receiver cannot stall it, so it must take the word that cycle.
// The point position is written through the csr_ channel (index 0..2 for x,
// y, z); csr_ready is always high and writes belong between items.
// Steps per item kind: add moves each entry up one place, then writes the
// new entry at index 0; a full table answers with the full status.
// find/delete read entries newest first until the frame key matches (not
// found on an empty table); delete then moves each later entry down one
// place. query reduces the query direction, then per entry runs up to 17
// reduction shifts, the 32-step square root and the 15-step divider of
// each cosine; an entry goes straight to the compare when either direction
// has zero length. An empty table answers with the empty status.
// One word is in flight at a time. Reset (synchronous) empties the table and
// clears the point to zero; entries need no clearing pass.
module closest_view_observation_select_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [cvos_pkg::KIND_W-1:0]           req_kind,
   input  logic [cvos_pkg::KEY_W-1:0]            req_frame_key,
   input  logic [cvos_pkg::KEY_W-1:0]            req_feature_handle,
   input  logic signed [cvos_pkg::COORD_W-1:0]   req_cam_x,
   input  logic signed [cvos_pkg::COORD_W-1:0]   req_cam_y,
   input  logic signed [cvos_pkg::COORD_W-1:0]   req_cam_z,
   output logic                                  rsp_valid,
   output logic [cvos_pkg::STATUS_W-1:0]         rsp_status,
   output logic [cvos_pkg::KEY_W-1:0]            rsp_found_feature,
   output logic signed [cvos_pkg::COS_W-1:0]     rsp_best_cosine,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [cvos_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [cvos_pkg::COORD_W-1:0]          csr_data
);
   import cvos_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic    csr_wr;

   // register writes are always taken
   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;

   cvos_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .sts       (sts)
   );

   cvos_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_kind           (req_kind),
      .req_frame_key      (req_frame_key),
      .req_feature_handle (req_feature_handle),
      .req_cam_x          (req_cam_x),
      .req_cam_y          (req_cam_y),
      .req_cam_z          (req_cam_z),
      .csr_wr             (csr_wr),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .cmd                (cmd),
      .sts                (sts),
      .rsp_status         (rsp_status),
      .rsp_found_feature  (rsp_found_feature),
      .rsp_best_cosine    (rsp_best_cosine)
   );

endmodule
